// ----- rtl/source_lexer_top_assert.svh -----
// Assertion macros for the lexer top level
`ifndef SOURCE_LEXER_TOP_ASSERT_SVH
`define SOURCE_LEXER_TOP_ASSERT_SVH
// Implication checked every clock, quiet during reset
`define SLX_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define SLX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/slx_pkg.sv -----
// ----------------------------------------------------------------------------
// slx_pkg
// Types, token kinds and keyword tables for the source lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package slx_pkg;
   localparam int POS_BITS = 20;
   localparam int KW_MAX_LEN = 6;
   localparam int KW_COUNT = 14;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [5:0] K_DOT = 6'd5;
   localparam logic [5:0] K_SLASH = 6'd18;
   localparam logic [5:0] K_IDENT = 6'd23;
   localparam logic [5:0] K_NUM = 6'd24;
   localparam logic [5:0] K_STRING = 6'd25;
   localparam logic [5:0] K_END = 6'd39;
   localparam logic [5:0] K_ERROR = 6'd40;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  error_code;
      logic [19:0] start_pos;
      logic [15:0] tok_len;
      logic [15:0] line;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [8:0] {
      M_IDLE    = 9'b000000001,
      M_OP      = 9'b000000010,
      M_SLASH   = 9'b000000100,
      M_COMMENT = 9'b000001000,
      M_STRING  = 9'b000010000,
      M_NUMI    = 9'b000100000,
      M_NUMD    = 9'b001000000,
      M_NUMF    = 9'b010000000,
      M_IDENT   = 9'b100000000
   } mode_type;

   // One queue slot: all tokens caused by one byte
   typedef struct packed {
      logic [2:0]           count;
      rsp_type [3:0]        tok;
   } batch_type;

   typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_type;

   function automatic kw_text_type kw_text(input int i);
      kw_text_type t;
      t = '0;
      case (i)
         0: t[1:0] = {"f", "i"};
         1: t[2:0] = {"r", "o", "f"};
         2: t[3:0] = {"e", "s", "l", "e"};
         3: t[1:0] = {"n", "f"};
         4: t[5:0] = {"n", "r", "u", "t", "e", "r"};
         5: t[3:0] = {"s", "i", "h", "t"};
         6: t[4:0] = {"e", "l", "i", "h", "w"};
         7: t[3:0] = {"e", "u", "r", "t"};
         8: t[4:0] = {"e", "s", "l", "a", "f"};
         9: t[4:0] = {"h", "c", "t", "a", "m"};
         10: t[5:0] = {"t", "c", "u", "r", "t", "s"};
         11: t[3:0] = {"m", "u", "n", "e"};
         12: t[2:0] = {"d", "o", "m"};
         default: t[3:0] = {"f", "o", "n", "e"};
      endcase
      return t;
   endfunction

   function automatic logic [2:0] kw_len(input int i);
      logic [2:0] l;
      case (i)
         0, 3: l = 3'd2;
         1, 12: l = 3'd3;
         2, 5, 7, 11, 13: l = 3'd4;
         6, 8, 9: l = 3'd5;
         default: l = 3'd6;
      endcase
      return l;
   endfunction

   function automatic logic [5:0] kw_kind(input int i);
      return 6'(26 + i);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [1:0] d);
      logic [16:0] s;
      s = {1'b0, v} + 17'(d);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/slx_front.sv -----
// ----------------------------------------------------------------------------
// slx_front
// Scanner state machine: classifies each byte and forms its token batch.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire slx_pkg::req_type   req,
   output slx_pkg::batch_type      batch
);
   slx_pkg::mode_type mode_ff, mode_in;
   logic [7:0] pend_ff, pend_in;
   logic [slx_pkg::POS_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [15:0] line_ff, line_in, len_ff, len_in;
   logic [slx_pkg::KW_MAX_LEN-1:0][7:0] chars_ff, chars_in;

   slx_pkg::batch_type b;
   logic [7:0] c;
   logic [slx_pkg::POS_BITS-1:0] p, p_next;
   logic [5:0] op_one, op_two, kw;
   logic [7:0] op_second;

   // append a token to the batch
   function automatic slx_pkg::batch_type add(
      input slx_pkg::batch_type bi, input logic [5:0] k, input logic [1:0] e,
      input logic [slx_pkg::POS_BITS-1:0] s, input logic [15:0] l, input logic [15:0] ln);
      slx_pkg::batch_type bo;
      bo = bi;
      bo.tok[bi.count[1:0]] = '{kind: k, error_code: e, start_pos: 20'(s), tok_len: l,
                                line: ln, last_of_run: 1'b0};
      bo.count = bi.count + 3'd1;
      return bo;
   endfunction

   function automatic logic [5:0] op_one_of(input logic [7:0] op);
      logic [5:0] k;
      case (op)
         "!": k = 6'd10;
         "=": k = 6'd12;
         "<": k = 6'd14;
         ">": k = 6'd16;
         "&": k = 6'd19;
         default: k = 6'd21;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] kw_of(input slx_pkg::kw_text_type t, input logic [15:0] l);
      logic [5:0] k;
      k = slx_pkg::K_IDENT;
      for (int i = slx_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (l == 16'(slx_pkg::kw_len(i)) && t == slx_pkg::kw_text(i)) k = slx_pkg::kw_kind(i);
      end
      return k;
   endfunction

   always_comb begin
      case (pend_ff)
         "!": begin op_one = 6'd10; op_two = 6'd11; op_second = "="; end
         "=": begin op_one = 6'd12; op_two = 6'd13; op_second = "="; end
         "<": begin op_one = 6'd14; op_two = 6'd15; op_second = "="; end
         ">": begin op_one = 6'd16; op_two = 6'd17; op_second = "="; end
         "&": begin op_one = 6'd19; op_two = 6'd20; op_second = "&"; end
         default: begin op_one = 6'd21; op_two = 6'd22; op_second = "|"; end
      endcase
   end

   always_comb begin
      kw = slx_pkg::K_IDENT;
      for (int i = slx_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (len_ff == 16'(slx_pkg::kw_len(i)) && chars_ff == slx_pkg::kw_text(i)) begin
            kw = slx_pkg::kw_kind(i);
         end
      end
   end

   always_comb begin
      logic idle_go;
      c = req.ch;
      p = pos_ff;
      p_next = pos_ff + 1'b1;
      b = '0;
      mode_in = mode_ff;
      pend_in = pend_ff;
      start_in = start_ff;
      line_in = line_ff;
      len_in = len_ff;
      chars_in = chars_ff;
      idle_go = 1'b0;
      case (mode_ff)
         slx_pkg::M_OP: begin
            if (c == op_second) begin
               b = add(b, op_two, slx_pkg::ERR_NONE, start_ff, 16'd2, line_ff);
               mode_in = slx_pkg::M_IDLE;
            end else begin
               b = add(b, op_one, slx_pkg::ERR_NONE, start_ff, 16'd1, line_ff);
               idle_go = 1'b1;
            end
         end
         slx_pkg::M_SLASH: begin
            if (c == "/") mode_in = slx_pkg::M_COMMENT;
            else begin
               b = add(b, slx_pkg::K_SLASH, slx_pkg::ERR_NONE, start_ff, 16'd1, line_ff);
               idle_go = 1'b1;
            end
         end
         slx_pkg::M_COMMENT: if (c == 8'h0A) idle_go = 1'b1;
         slx_pkg::M_STRING: begin
            len_in = slx_pkg::sat_inc(len_ff, 2'd1);
            if (c == "\"") begin
               b = add(b, slx_pkg::K_STRING, slx_pkg::ERR_NONE, start_ff, len_in, line_ff);
               mode_in = slx_pkg::M_IDLE;
            end else if (c == 8'h0A) line_in = slx_pkg::sat_inc(line_ff, 2'd1);
         end
         slx_pkg::M_NUMI: begin
            if (slx_pkg::is_digit(c)) len_in = slx_pkg::sat_inc(len_ff, 2'd1);
            else if (c == ".") mode_in = slx_pkg::M_NUMD;
            else begin
               b = add(b, slx_pkg::K_NUM, slx_pkg::ERR_NONE, start_ff, len_ff, line_ff);
               idle_go = 1'b1;
            end
         end
         slx_pkg::M_NUMD: begin
            if (slx_pkg::is_digit(c)) begin
               len_in = slx_pkg::sat_inc(len_ff, 2'd2);
               mode_in = slx_pkg::M_NUMF;
            end else begin
               b = add(b, slx_pkg::K_NUM, slx_pkg::ERR_NONE, start_ff, len_ff, line_ff);
               b = add(b, slx_pkg::K_DOT, slx_pkg::ERR_NONE, p - 1'b1, 16'd1, line_ff);
               idle_go = 1'b1;
            end
         end
         slx_pkg::M_NUMF: begin
            if (slx_pkg::is_digit(c)) len_in = slx_pkg::sat_inc(len_ff, 2'd1);
            else begin
               b = add(b, slx_pkg::K_NUM, slx_pkg::ERR_NONE, start_ff, len_ff, line_ff);
               idle_go = 1'b1;
            end
         end
         slx_pkg::M_IDENT: begin
            if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c)) begin
               if (len_ff < 16'(slx_pkg::KW_MAX_LEN))
                  chars_in[len_ff[$clog2(slx_pkg::KW_MAX_LEN)-1:0]] = c;
               len_in = slx_pkg::sat_inc(len_ff, 2'd1);
            end else begin
               b = add(b, kw, slx_pkg::ERR_NONE, start_ff, len_ff, line_ff);
               idle_go = 1'b1;
            end
         end
         default: idle_go = 1'b1;
      endcase

      if (idle_go) begin
         mode_in = slx_pkg::M_IDLE;
         case (c)
            "(": b = add(b, 6'd0, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            ")": b = add(b, 6'd1, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "{": b = add(b, 6'd2, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "}": b = add(b, 6'd3, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            ",": b = add(b, 6'd4, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            ".": b = add(b, 6'd5, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "-": b = add(b, 6'd6, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "+": b = add(b, 6'd7, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            ";": b = add(b, 6'd8, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "*": b = add(b, 6'd9, slx_pkg::ERR_NONE, p, 16'd1, line_ff);
            "!", "=", "<", ">", "&", "|": begin
               mode_in = slx_pkg::M_OP;
               start_in = p;
               len_in = 16'd1;
               pend_in = c;
            end
            "/": begin mode_in = slx_pkg::M_SLASH; start_in = p; len_in = 16'd1; end
            " ", 8'h0D, 8'h09: ;
            8'h0A: line_in = slx_pkg::sat_inc(line_ff, 2'd1);
            "\"": begin mode_in = slx_pkg::M_STRING; start_in = p; len_in = 16'd1; end
            default: begin
               if (slx_pkg::is_digit(c)) begin
                  mode_in = slx_pkg::M_NUMI; start_in = p; len_in = 16'd1;
               end else if (slx_pkg::is_alpha(c)) begin
                  mode_in = slx_pkg::M_IDENT; start_in = p; len_in = 16'd1;
                  // drop bytes of an older word so the full-width keyword compare holds
                  chars_in = '0;
                  chars_in[0] = c;
               end else begin
                  b = add(b, slx_pkg::K_ERROR, slx_pkg::ERR_UNEXPECTED, p, 16'd1, line_ff);
               end
            end
         endcase
      end

      if (req.is_last) begin
         case (mode_in)
            slx_pkg::M_OP:
               b = add(b, op_one_of(pend_in), slx_pkg::ERR_NONE, start_in, 16'd1, line_in);
            slx_pkg::M_SLASH:
               b = add(b, slx_pkg::K_SLASH, slx_pkg::ERR_NONE, start_in, 16'd1, line_in);
            slx_pkg::M_STRING:
               b = add(b, slx_pkg::K_ERROR, slx_pkg::ERR_UNTERMINATED, start_in, len_in,
                       line_in);
            slx_pkg::M_NUMI, slx_pkg::M_NUMF:
               b = add(b, slx_pkg::K_NUM, slx_pkg::ERR_NONE, start_in, len_in, line_in);
            slx_pkg::M_NUMD: begin
               b = add(b, slx_pkg::K_NUM, slx_pkg::ERR_NONE, start_in, len_in, line_in);
               b = add(b, slx_pkg::K_DOT, slx_pkg::ERR_NONE, p, 16'd1, line_in);
            end
            slx_pkg::M_IDENT:
               b = add(b, kw_of(chars_in, len_in), slx_pkg::ERR_NONE, start_in, len_in,
                       line_in);
            default: ;
         endcase
         b = add(b, slx_pkg::K_END, slx_pkg::ERR_NONE, p_next, 16'd0, line_in);
      end
      if (b.count != 3'd0) b.tok[b.count[1:0] - 2'd1].last_of_run = 1'b1;
      pos_in = p_next;
   end

   assign batch = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= slx_pkg::M_IDLE;
         pend_ff <= '0;
         pos_ff <= '0;
         start_ff <= '0;
         line_ff <= 16'd1;
         len_ff <= '0;
         chars_ff <= '0;
      end else if (step) begin
         if (req.is_last) begin
            // end of source: back to reset values
            mode_ff <= slx_pkg::M_IDLE;
            pend_ff <= '0;
            pos_ff <= '0;
            start_ff <= '0;
            line_ff <= 16'd1;
            len_ff <= '0;
            chars_ff <= '0;
         end else begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            pos_ff <= pos_in;
            start_ff <= start_in;
            line_ff <= line_in;
            len_ff <= len_in;
            chars_ff <= chars_in;
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/slx_queue.sv -----
// ----------------------------------------------------------------------------
// slx_queue
// Short FIFO of token batches between scanner and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire slx_pkg::batch_type push_data,
   input  wire logic               pop,
   output slx_pkg::batch_type      head,
   output logic                    empty,
   output logic                    full
);
   slx_pkg::batch_type mem_ff [slx_pkg::QUEUE_DEPTH];
   logic [slx_pkg::QUEUE_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [slx_pkg::QUEUE_PTR_BITS:0] cnt_ff;

   assign empty = cnt_ff == '0;
   assign full = cnt_ff == (slx_pkg::QUEUE_PTR_BITS + 1)'(slx_pkg::QUEUE_DEPTH);
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/slx_back.sv -----
// ----------------------------------------------------------------------------
// slx_back
// Output sequencer: sends the tokens of each batch one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module slx_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire slx_pkg::batch_type head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output slx_pkg::rsp_type        rsp_data
);
   logic [1:0] idx_ff;
   logic valid_ff;
   slx_pkg::rsp_type data_ff;
   logic load, last_tok, have;

   // batches with no tokens are dropped without output
   assign have = !empty && head.count != 3'd0;
   assign load = have && (!valid_ff || rsp_ready);
   assign last_tok = {1'b0, idx_ff} + 3'd1 == head.count;
   assign pop = !empty && (head.count == 3'd0 || (load && last_tok));

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_ff @(posedge clock) begin
      if (load) data_ff <= head.tok[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= last_tok ? 2'd0 : idx_ff + 2'd1;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/source_lexer_top.sv -----
// Source lexer. Bytes enter on req_ (ch, is_last) with valid/ready; tokens
// leave on rsp_ (kind, error_code, start_pos, tok_len, line, last_of_run).
// One byte is accepted per cycle while the batch queue has room; the scanner
// forms all tokens a byte causes (up to four) in the accepting cycle.
// A token passes the batch queue and then the output register before its
// rsp_valid rises. Output runs at one token per cycle while the receiver is
// ready, so a byte causing several tokens holds the output side for one transfer
// per token; the four-entry batch queue lets the input continue as it drains.
// Synchronous reset empties the queue and returns the scanner to start of
// source (offset 0, line 1). A stalled receiver holds rsp_ data steady; once
// the queue fills, req_ready drops until space frees.
// After the byte marked is_last, the end token is emitted and the scanner
// restarts for a new source.
`default_nettype none
`include "source_lexer_top_assert.svh"
module source_lexer_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire slx_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output slx_pkg::rsp_type        rsp_data
);
   slx_pkg::batch_type batch, head;
   logic step, pop, empty, full;

   assign req_ready = !full;
   assign step = req_valid && req_ready;

   slx_front u_front (.clock, .reset, .step, .req(req_data), .batch);
   slx_queue u_queue (.clock, .reset, .push(step), .push_data(batch), .pop,
                      .head, .empty, .full);
   slx_back u_back (.clock, .reset, .head, .empty, .pop, .rsp_valid, .rsp_ready,
                    .rsp_data);

   `SLX_ASSERT_IMP(a_pop_nonempty, pop, !empty, "pop from empty queue")
   `SLX_ASSERT_IMP(a_batch_end, step && req_data.is_last,
      batch.count != 3'd0 && batch.tok[batch.count[1:0] - 2'd1].kind == slx_pkg::K_END,
      "last byte without end token")
   `SLX_ASSERT_NEXT(a_valid_after_load, !empty && head.count != 3'd0 && !rsp_valid,
      rsp_valid, "output not loaded")
endmodule
`default_nettype wire

// ----- dv/source_lexer_top_tb.sv -----
// ----------------------------------------------------------------------------
// source_lexer_top_tb
// Streams short source texts into the lexer one byte per transfer and checks
// every token against a cycle-free scanner model kept in this testbench.
// Directed sources cover operators, words, numbers, strings, comments, bad bytes and the corner cases; random
// sources are built from well-formed fragments mixed with noise bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module source_lexer_top_tb;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   slx_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   slx_pkg::rsp_type rsp_data;

   source_lexer_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // scanner state
   slx_pkg::mode_type scan_mode;
   logic [7:0]  pending_op;
   logic [19:0] position;
   logic [19:0] token_start;
   logic [15:0] line_count;
   logic [7:0]  word_chars [0:slx_pkg::KW_MAX_LEN-1];
   logic [15:0] run_len;
   int          batch_count;

   slx_pkg::rsp_type expected_tokens [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          long_hold = 0;
   bit          no_idle = 1'b0;

   string keywords [14] = '{"if", "for", "else", "fn", "return", "this", "while",
                            "true", "false", "match", "struct", "enum", "mod", "enof"};

   function automatic logic [15:0] add_sat(logic [15:0] v, int d);
      return (int'(v) + d > 65535) ? 16'hFFFF : 16'(int'(v) + d);
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   task automatic clear_scanner();
      scan_mode = slx_pkg::M_IDLE;
      pending_op = '0;
      position = '0;
      token_start = '0;
      line_count = 16'd1;
      for (int i = 0; i < slx_pkg::KW_MAX_LEN; i++) word_chars[i] = '0;
      run_len = '0;
   endtask

   task automatic push_token(logic [5:0] kind, logic [1:0] err, logic [19:0] start,
                             logic [15:0] len);
      slx_pkg::rsp_type t;
      if (batch_count >= 4) return;
      t = '{kind: kind, error_code: err, start_pos: start, tok_len: len,
            line: line_count, last_of_run: 1'b0};
      expected_tokens.push_back(t);
      batch_count++;
   endtask

   // one-char kind, two-char kind, expected second byte
   task automatic op_codes(logic [7:0] op, output logic [5:0] one, output logic [5:0] two,
                           output logic [7:0] second);
      case (op)
         "!": begin one = 6'd10; two = 6'd11; second = "="; end
         "=": begin one = 6'd12; two = 6'd13; second = "="; end
         "<": begin one = 6'd14; two = 6'd15; second = "="; end
         ">": begin one = 6'd16; two = 6'd17; second = "="; end
         "&": begin one = 6'd19; two = 6'd20; second = "&"; end
         default: begin one = 6'd21; two = 6'd22; second = "|"; end
      endcase
   endtask

   task automatic close_word();
      logic [5:0] kind;
      bit         hit;
      kind = slx_pkg::K_IDENT;
      for (int i = 0; i < 14; i++) begin
         if (kind == slx_pkg::K_IDENT && run_len == keywords[i].len() &&
             run_len <= slx_pkg::KW_MAX_LEN) begin
            hit = 1'b1;
            for (int j = 0; j < keywords[i].len(); j++)
               if (word_chars[j] != keywords[i][j]) hit = 1'b0;
            if (hit) kind = 6'(26 + i);
         end
      end
      push_token(kind, slx_pkg::ERR_NONE, token_start, run_len);
   endtask

   task automatic open_token(slx_pkg::mode_type m, logic [19:0] p);
      scan_mode = m;
      token_start = p;
      run_len = 16'd1;
   endtask

   task automatic fresh_byte(logic [7:0] c, logic [19:0] p);
      scan_mode = slx_pkg::M_IDLE;
      case (c)
         "(": push_token(6'd0, slx_pkg::ERR_NONE, p, 16'd1);
         ")": push_token(6'd1, slx_pkg::ERR_NONE, p, 16'd1);
         "{": push_token(6'd2, slx_pkg::ERR_NONE, p, 16'd1);
         "}": push_token(6'd3, slx_pkg::ERR_NONE, p, 16'd1);
         ",": push_token(6'd4, slx_pkg::ERR_NONE, p, 16'd1);
         ".": push_token(slx_pkg::K_DOT, slx_pkg::ERR_NONE, p, 16'd1);
         "-": push_token(6'd6, slx_pkg::ERR_NONE, p, 16'd1);
         "+": push_token(6'd7, slx_pkg::ERR_NONE, p, 16'd1);
         ";": push_token(6'd8, slx_pkg::ERR_NONE, p, 16'd1);
         "*": push_token(6'd9, slx_pkg::ERR_NONE, p, 16'd1);
         "!", "=", "<", ">", "&", "|": begin
            open_token(slx_pkg::M_OP, p);
            pending_op = c;
         end
         "/": open_token(slx_pkg::M_SLASH, p);
         8'h20, 8'h0D, 8'h09: ;
         8'h0A: line_count = add_sat(line_count, 1);
         8'h22: open_token(slx_pkg::M_STRING, p);
         default: begin
            if (digit(c)) open_token(slx_pkg::M_NUMI, p);
            else if (alpha(c)) begin
               open_token(slx_pkg::M_IDENT, p);
               word_chars[0] = c;
            end else push_token(slx_pkg::K_ERROR, slx_pkg::ERR_UNEXPECTED, p, 16'd1);
         end
      endcase
   endtask

   // Work out every token one accepted byte causes
   task automatic scan_byte(logic [7:0] c, bit last);
      logic [19:0] p;
      logic [5:0]  one, two;
      logic [7:0]  second;
      p = position;
      batch_count = 0;
      case (scan_mode)
         slx_pkg::M_OP: begin
            op_codes(pending_op, one, two, second);
            if (c == second) begin
               push_token(two, slx_pkg::ERR_NONE, token_start, 16'd2);
               scan_mode = slx_pkg::M_IDLE;
            end else begin
               push_token(one, slx_pkg::ERR_NONE, token_start, 16'd1);
               fresh_byte(c, p);
            end
         end
         slx_pkg::M_SLASH: begin
            if (c == "/") scan_mode = slx_pkg::M_COMMENT;
            else begin
               push_token(slx_pkg::K_SLASH, slx_pkg::ERR_NONE, token_start, 16'd1);
               fresh_byte(c, p);
            end
         end
         slx_pkg::M_COMMENT: if (c == 8'h0A) fresh_byte(c, p);
         slx_pkg::M_STRING: begin
            run_len = add_sat(run_len, 1);
            if (c == 8'h22) begin
               push_token(slx_pkg::K_STRING, slx_pkg::ERR_NONE, token_start, run_len);
               scan_mode = slx_pkg::M_IDLE;
            end else if (c == 8'h0A) line_count = add_sat(line_count, 1);
         end
         slx_pkg::M_NUMI: begin
            if (digit(c)) run_len = add_sat(run_len, 1);
            else if (c == ".") scan_mode = slx_pkg::M_NUMD;
            else begin
               push_token(slx_pkg::K_NUM, slx_pkg::ERR_NONE, token_start, run_len);
               fresh_byte(c, p);
            end
         end
         slx_pkg::M_NUMD: begin
            if (digit(c)) begin
               run_len = add_sat(run_len, 2);
               scan_mode = slx_pkg::M_NUMF;
            end else begin
               push_token(slx_pkg::K_NUM, slx_pkg::ERR_NONE, token_start, run_len);
               push_token(slx_pkg::K_DOT, slx_pkg::ERR_NONE, p - 20'd1, 16'd1);
               fresh_byte(c, p);
            end
         end
         slx_pkg::M_NUMF: begin
            if (digit(c)) run_len = add_sat(run_len, 1);
            else begin
               push_token(slx_pkg::K_NUM, slx_pkg::ERR_NONE, token_start, run_len);
               fresh_byte(c, p);
            end
         end
         slx_pkg::M_IDENT: begin
            if (alpha(c) || digit(c)) begin
               if (run_len < slx_pkg::KW_MAX_LEN) word_chars[run_len] = c;
               run_len = add_sat(run_len, 1);
            end else begin
               close_word();
               fresh_byte(c, p);
            end
         end
         default: fresh_byte(c, p);
      endcase
      position = p + 20'd1;
      if (last) begin
         case (scan_mode)
            slx_pkg::M_OP: begin
               op_codes(pending_op, one, two, second);
               push_token(one, slx_pkg::ERR_NONE, token_start, 16'd1);
            end
            slx_pkg::M_SLASH:
               push_token(slx_pkg::K_SLASH, slx_pkg::ERR_NONE, token_start, 16'd1);
            slx_pkg::M_STRING:
               push_token(slx_pkg::K_ERROR, slx_pkg::ERR_UNTERMINATED, token_start, run_len);
            slx_pkg::M_NUMI, slx_pkg::M_NUMF:
               push_token(slx_pkg::K_NUM, slx_pkg::ERR_NONE, token_start, run_len);
            slx_pkg::M_NUMD: begin
               push_token(slx_pkg::K_NUM, slx_pkg::ERR_NONE, token_start, run_len);
               push_token(slx_pkg::K_DOT, slx_pkg::ERR_NONE, p, 16'd1);
            end
            slx_pkg::M_IDENT: close_word();
            default: ;
         endcase
         push_token(slx_pkg::K_END, slx_pkg::ERR_NONE, position, 16'd0);
         clear_scanner();
      end
      if (batch_count > 0)
         expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      slx_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0)
            report_mismatch($sformatf("unexpected token kind %0d", rsp_data.kind));
         else begin
            e = expected_tokens.pop_front();
            if (rsp_data.kind !== e.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_data.kind, e.kind));
            if (rsp_data.error_code !== e.error_code)
               report_mismatch($sformatf("error_code %0d, want %0d",
                                         rsp_data.error_code, e.error_code));
            if (rsp_data.start_pos !== e.start_pos)
               report_mismatch($sformatf("start_pos %0d, want %0d",
                                         rsp_data.start_pos, e.start_pos));
            if (rsp_data.tok_len !== e.tok_len)
               report_mismatch($sformatf("tok_len %0d, want %0d", rsp_data.tok_len, e.tok_len));
            if (rsp_data.line !== e.line)
               report_mismatch($sformatf("line %0d, want %0d", rsp_data.line, e.line));
            if (rsp_data.last_of_run !== e.last_of_run)
               report_mismatch($sformatf("last_of_run %0d, want %0d",
                                         rsp_data.last_of_run, e.last_of_run));
         end
      end
   end

   // Receiver: random stalls per transfer, or one long hold on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (long_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("source_lexer_top_tb NOT OK");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] c, bit last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{ch: c, is_last: last};
      do @(posedge clock); while (!req_ready);
      scan_byte(c, last);
   endtask

   task automatic send_text(string s, bit close_source);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], close_source && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() > 0) @(posedge clock);
   endtask

   task automatic test_operators();
      send_text("(){},.-+;*!!=x==<<=>>=&&&|||/a< ", 1'b0);
      send_text("<", 1'b1);
   endtask

   task automatic test_words();
      send_text("if enof enum mod iff return_ x9\n", 1'b0);
      send_text("while", 1'b1);
   endtask

   task automatic test_numbers_strings();
      send_text("7.5 3.x 2..\"a\nb\"//c\n/", 1'b0);
      send_text("9.", 1'b1);
      send_text("\"open", 1'b1);
   endtask

   task automatic test_bad_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte("#", 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Receiver holds off while the sender keeps offering, filling the queue
   task automatic test_backpressure();
      no_idle = 1'b1;
      long_hold = 80;
      send_text("(((((((((((((((((((((((((((((((.1.;", 1'b1);
      no_idle = 1'b0;
      wait_drained();
   endtask

   task automatic add_fragment(ref logic [7:0] src [$]);
      string w;
      int    n;
      case ($urandom_range(0, 11))
         0, 1: w = keywords[$urandom_range(0, 13)];
         2, 3: begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               src.push_back(i > 0 && $urandom_range(0, 3) == 0 ? 8'("0" + $urandom_range(0, 9))
                             : (i % 2 ? 8'("A" + $urandom_range(0, 25))
                                      : 8'("a" + $urandom_range(0, 25))));
         end
         4: begin
            w = $sformatf("%0d", $urandom_range(0, 9999));
            if ($urandom_range(0, 1)) w = {w, ".", $sformatf("%0d", $urandom_range(0, 99))};
         end
         5: begin
            src.push_back(8'h22);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
               src.push_back($urandom_range(0, 3) == 0 ? 8'h0A : 8'("a" + $urandom_range(0, 25)));
            if ($urandom_range(0, 7) != 0) src.push_back(8'h22);
         end
         6, 7: begin
            string ops [18] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*",
                                "!=", "==", "<=", ">=", "&&", "||", "/", "!"};
            w = ops[$urandom_range(0, 17)];
         end
         8: w = "// note\n";
         9: src.push_back(8'($urandom_range(0, 255)));
         default: w = ($urandom_range(0, 1)) ? " " : "\n";
      endcase
      for (int i = 0; i < w.len(); i++) src.push_back(w[i]);
      src.push_back($urandom_range(0, 2) == 0 ? 8'h09 : 8'h20);
   endtask

   task automatic test_random_sources();
      logic [7:0] src [$];
      int         sent;
      sent = 0;
      while (sent < 260) begin
         src.delete();
         repeat ($urandom_range(2, 12)) add_fragment(src);
         // drop the trailing separator now and then so tokens close at the end
         if ($urandom_range(0, 1)) void'(src.pop_back());
         no_idle = ($urandom_range(0, 5) == 0);
         foreach (src[i]) send_byte(src[i], i == src.size() - 1);
         sent += src.size();
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_scanner();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_words();
      test_numbers_strings();
      test_bad_bytes();
      wait_drained();
      test_backpressure();
      test_random_sources();
      wait_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("source_lexer_top_tb OK");
      else
         $display("source_lexer_top_tb NOT OK");
      $finish;
   end
endmodule
